FILE: rtl/assert_macros.svh
// Assertion macros shared by the multiplier and controller modules of the hash block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/smrh_pkg.sv
// Package with constants, types and command structs of the striped hash block.
package smrh_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned LEN_W  = 32;
    localparam int unsigned IDX_W  = 30;

    localparam logic [WORD_W-1:0] PHI_K = 64'h9E3779B97F4A7C15;
    localparam logic [WORD_W-1:0] MIX_A = 64'h85EBCA77C2B2AE3D;
    localparam logic [WORD_W-1:0] MIX_B = 64'hBF58476D1CE4E5B9;
    localparam logic [WORD_W-1:0] MIX_C = 64'h94D049BB133111EB;

    localparam logic [IDX_W-1:0] INDEX_MAX = {IDX_W{1'b1}};

    localparam logic [5:0] ROT_TABLE [2][4] = '{
        '{6'd23, 6'd47, 6'd13, 6'd37},
        '{6'd11, 6'd19, 6'd35, 6'd47}
    };

    localparam int unsigned FIN_SH1 = 29;
    localparam int unsigned FIN_SH2 = 31;
    localparam int unsigned FIN_SH3 = 37;
    localparam int unsigned FIN_SH4 = 41;

    typedef enum logic [1:0] {
        K_PHI,
        K_MIX_A,
        K_MIX_B,
        K_MIX_C
    } t_const_sel;

    typedef enum logic [2:0] {
        OPND_LEN,
        OPND_BASE_NEW,
        OPND_BASE,
        OPND_ABSORB,
        OPND_FOLD,
        OPND_MIX31,
        OPND_MIX37
    } t_opnd_sel;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_LO,
        MUL_CROSS_HI,
        MUL_CROSS_LO
    } t_mul_step;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LEN_WAIT,
        ST_LANE_WAIT,
        ST_ABS_MUL,
        ST_ABS_WAIT,
        ST_FIN_MUL1,
        ST_FIN_WAIT1,
        ST_FIN_WAIT2,
        ST_FIN_WAIT3,
        ST_OUT
    } t_ctrl_state;

    typedef struct packed {
        logic       capture;
        logic       mul_start;
        t_opnd_sel  opnd;
        t_const_sel csel;
        logic       base_load;
        logic       lane_wr_init;
        logic [1:0] lane_k;
        logic       absorb_wr;
        logic       idx_step;
        logic       out_load;
        logic       state_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic first;
        logic last;
        logic absorb_en;
        logic mul_done;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/smrh_mul.sv
// Multi-cycle 64x64 low-half multiplier by a selectable constant, one 32x32 product a cycle.
`include "assert_macros.svh"

module smrh_mul import smrh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_operand,
    input  t_const_sel        i_csel,
    output logic              o_done,
    output logic [WORD_W-1:0] o_result
);

    localparam int unsigned HALF_W = WORD_W / 2;

    t_mul_step           r_step;
    logic                r_done;
    logic [WORD_W-1:0]   r_a;
    logic [WORD_W-1:0]   r_c;
    logic [WORD_W-1:0]   r_p;
    logic [HALF_W-1:0]   r_x;
    logic [WORD_W-1:0]   r_res;
    logic [HALF_W-1:0]   w_mx;
    logic [HALF_W-1:0]   w_my;
    logic [WORD_W-1:0]   w_prod;

    function automatic logic [WORD_W-1:0] const_value(t_const_sel s);
        logic [WORD_W-1:0] v;
        unique case (s)
            K_PHI:   v = PHI_K;
            K_MIX_A: v = MIX_A;
            K_MIX_B: v = MIX_B;
            K_MIX_C: v = MIX_C;
            default: v = PHI_K;
        endcase
        return v;
    endfunction

    always_comb begin
        unique case (r_step)
            MUL_LO: begin
                w_mx = r_a[HALF_W-1:0];
                w_my = r_c[HALF_W-1:0];
            end
            MUL_CROSS_HI: begin
                w_mx = r_a[WORD_W-1:HALF_W];
                w_my = r_c[HALF_W-1:0];
            end
            default: begin
                w_mx = r_a[HALF_W-1:0];
                w_my = r_c[WORD_W-1:HALF_W];
            end
        endcase
    end

    assign w_prod = {{HALF_W{1'b0}}, w_mx} * {{HALF_W{1'b0}}, w_my};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= MUL_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_step)
                MUL_IDLE: begin
                    if (i_start) begin
                        r_step <= MUL_LO;
                    end
                end
                MUL_LO:       r_step <= MUL_CROSS_HI;
                MUL_CROSS_HI: r_step <= MUL_CROSS_LO;
                MUL_CROSS_LO: begin
                    r_step <= MUL_IDLE;
                    r_done <= 1'b1;
                end
                default:      r_step <= MUL_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && r_step == MUL_IDLE) begin
            r_a <= i_operand;
            r_c <= const_value(i_csel);
        end
        if (r_step == MUL_LO) begin
            r_p <= w_prod;
        end
        if (r_step == MUL_CROSS_HI) begin
            r_x <= w_prod[HALF_W-1:0];
        end
        if (r_step == MUL_CROSS_LO) begin
            r_res <= {r_p[WORD_W-1:HALF_W] + r_x + w_prod[HALF_W-1:0], r_p[HALF_W-1:0]};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    `ASSERT_IMPLIES(a_start_when_idle, i_clk, i_rst_n, i_start, r_step == MUL_IDLE)
    `ASSERT_NEXT(a_done_after_last_step, i_clk, i_rst_n, r_step == MUL_CROSS_LO, r_done)
    `ASSERT_IMPLIES(a_done_means_idle, i_clk, i_rst_n, r_done, r_step == MUL_IDLE)

endmodule

FILE: rtl/smrh_dp.sv
// Datapath of the hash block: lanes, word position, operand selection and result register.
module smrh_dp import smrh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_data,
    input  logic [WORD_W-1:0] i_data_word,
    input  logic              i_first_word,
    input  logic              i_last_word,
    input  logic [WORD_W-1:0] i_seed_value,
    input  logic [LEN_W-1:0]  i_message_bytes,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    output logic [WORD_W-1:0] o_hash_value,
    output logic              o_out_valid,
    input  logic              i_out_stall
);

    localparam int unsigned POS_W = LEN_W + 2;

    logic              r_rot_set;
    logic [WORD_W-1:0] r_data;
    logic              r_first;
    logic              r_last;
    logic [WORD_W-1:0] r_seed;
    logic [LEN_W-1:0]  r_len;
    logic [IDX_W-1:0]  r_idx;
    logic [WORD_W-1:0] r_lane [4];
    logic [WORD_W-1:0] r_base;
    logic [WORD_W-1:0] r_hash;
    logic              r_out_valid;

    logic [POS_W-1:0]  w_len_ext;
    logic [POS_W-1:0]  w_stripe_end;
    logic [POS_W-1:0]  w_pos;
    logic [POS_W-1:0]  w_pos_end;
    logic              w_in_stripe;
    logic              w_full;
    logic              w_part;
    logic [1:0]        w_abs_k;
    logic [5:0]        w_rot;
    logic [WORD_W-1:0] w_abs_data;
    logic [WORD_W-1:0] w_abs_opnd;
    logic [WORD_W-1:0] w_fold;
    logic [WORD_W-1:0] w_operand;
    logic [WORD_W-1:0] w_res;
    logic              w_mul_done;
    logic              w_out_free;

    function automatic logic [WORD_W-1:0] byte_mask(logic [2:0] n);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (3'(i) < n) begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    function automatic logic [WORD_W-1:0] rotl64(logic [WORD_W-1:0] x, logic [5:0] k);
        logic [2*WORD_W-1:0] d;
        d = {x, x} << k;
        return d[2*WORD_W-1:WORD_W];
    endfunction

    smrh_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.mul_start),
        .i_operand (w_operand),
        .i_csel    (i_cmd.csel),
        .o_done    (w_mul_done),
        .o_result  (w_res)
    );

    assign w_len_ext    = {2'b00, r_len};
    assign w_stripe_end = {1'b0, r_idx[IDX_W-1:2], 5'b00000} + POS_W'(32);
    assign w_pos        = {1'b0, r_idx, 3'b000};
    assign w_pos_end    = w_pos + POS_W'(8);
    assign w_in_stripe  = (w_stripe_end <= w_len_ext);
    assign w_full       = (w_pos_end <= w_len_ext);
    assign w_part       = (w_pos < w_len_ext);

    assign w_abs_k    = w_in_stripe ? r_idx[1:0] : 2'd0;
    assign w_rot      = ROT_TABLE[r_rot_set][w_abs_k];
    assign w_abs_data = (w_in_stripe || w_full) ? r_data : (r_data & byte_mask(r_len[2:0]));
    assign w_abs_opnd = r_lane[w_abs_k] ^ rotl64(w_abs_data, w_rot);
    assign w_fold     = r_lane[0] ^ r_lane[1] ^ (r_lane[2] ^ r_lane[3]);

    always_comb begin
        unique case (i_cmd.opnd)
            OPND_LEN:      w_operand = {{(WORD_W-LEN_W){1'b0}}, r_len};
            OPND_BASE_NEW: w_operand = r_seed ^ w_res;
            OPND_BASE:     w_operand = r_base;
            OPND_ABSORB:   w_operand = w_abs_opnd;
            OPND_FOLD:     w_operand = w_fold ^ (w_fold >> FIN_SH1);
            OPND_MIX31:    w_operand = w_res ^ (w_res >> FIN_SH2);
            OPND_MIX37:    w_operand = w_res ^ (w_res >> FIN_SH3);
            default:       w_operand = r_base;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_set <= 1'b0;
        end else if (i_cfg_valid) begin
            r_rot_set <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_data  <= i_data_word;
            r_first <= i_first_word;
            r_last  <= i_last_word;
            if (i_first_word) begin
                r_seed <= i_seed_value;
            end
        end
        if (i_cmd.base_load) begin
            r_base <= r_seed ^ w_res;
        end
        if (i_cmd.out_load) begin
            r_hash <= w_res ^ (w_res >> FIN_SH4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.state_clr) begin
            r_len <= '0;
            r_idx <= '0;
            for (int i = 0; i < 4; i++) begin
                r_lane[i] <= '0;
            end
        end else begin
            if (i_cmd.capture && i_first_word) begin
                r_len <= i_message_bytes;
                r_idx <= '0;
            end else if (i_cmd.idx_step && r_idx != INDEX_MAX) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.lane_wr_init) begin
                r_lane[i_cmd.lane_k] <= w_res;
            end else if (i_cmd.absorb_wr) begin
                r_lane[w_abs_k] <= w_res;
            end
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.first     = r_first;
    assign o_stat.last      = r_last;
    assign o_stat.absorb_en = w_in_stripe || w_part;
    assign o_stat.mul_done  = w_mul_done;
    assign o_stat.out_free  = w_out_free;

    assign o_hash_value = r_hash;
    assign o_out_valid  = r_out_valid;

endmodule

FILE: rtl/smrh_ctrl.sv
// Controller state machine that sequences seeding, absorbing and finishing of the hash.
`include "assert_macros.svh"

module smrh_ctrl import smrh_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic [1:0]  r_k;
    logic [1:0]  n_k;
    logic        w_in_wait;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        n_k        = r_k;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_stat.first) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.opnd      = OPND_LEN;
                    o_cmd.csel      = K_PHI;
                    n_state         = ST_LEN_WAIT;
                end else if (i_stat.absorb_en) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.opnd      = OPND_ABSORB;
                    o_cmd.csel      = K_PHI;
                    n_state         = ST_ABS_WAIT;
                end else begin
                    o_cmd.idx_step = 1'b1;
                    n_state        = i_stat.last ? ST_FIN_MUL1 : ST_IDLE;
                end
            end
            ST_LEN_WAIT: begin
                if (i_stat.mul_done) begin
                    o_cmd.base_load = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.opnd      = OPND_BASE_NEW;
                    o_cmd.csel      = K_PHI;
                    n_k             = 2'd0;
                    n_state         = ST_LANE_WAIT;
                end
            end
            ST_LANE_WAIT: begin
                if (i_stat.mul_done) begin
                    o_cmd.lane_wr_init = 1'b1;
                    o_cmd.lane_k       = r_k;
                    if (r_k == 2'd3) begin
                        n_state = ST_ABS_MUL;
                    end else begin
                        o_cmd.mul_start = 1'b1;
                        o_cmd.opnd      = OPND_BASE;
                        o_cmd.csel      = t_const_sel'(r_k + 2'd1);
                        n_k             = r_k + 2'd1;
                    end
                end
            end
            ST_ABS_MUL: begin
                if (i_stat.absorb_en) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.opnd      = OPND_ABSORB;
                    o_cmd.csel      = K_PHI;
                    n_state         = ST_ABS_WAIT;
                end else begin
                    o_cmd.idx_step = 1'b1;
                    n_state        = i_stat.last ? ST_FIN_MUL1 : ST_IDLE;
                end
            end
            ST_ABS_WAIT: begin
                if (i_stat.mul_done) begin
                    o_cmd.absorb_wr = 1'b1;
                    o_cmd.idx_step  = 1'b1;
                    n_state         = i_stat.last ? ST_FIN_MUL1 : ST_IDLE;
                end
            end
            ST_FIN_MUL1: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.opnd      = OPND_FOLD;
                o_cmd.csel      = K_MIX_A;
                n_state         = ST_FIN_WAIT1;
            end
            ST_FIN_WAIT1: begin
                if (i_stat.mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.opnd      = OPND_MIX31;
                    o_cmd.csel      = K_MIX_B;
                    n_state         = ST_FIN_WAIT2;
                end
            end
            ST_FIN_WAIT2: begin
                if (i_stat.mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.opnd      = OPND_MIX37;
                    o_cmd.csel      = K_PHI;
                    n_state         = ST_FIN_WAIT3;
                end
            end
            ST_FIN_WAIT3: begin
                if (i_stat.mul_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.state_clr = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_in_wait = (r_state == ST_LEN_WAIT)  || (r_state == ST_LANE_WAIT) ||
                       (r_state == ST_ABS_WAIT)  || (r_state == ST_FIN_WAIT1) ||
                       (r_state == ST_FIN_WAIT2) || (r_state == ST_FIN_WAIT3);

    `ASSERT_IMPLIES(a_load_only_when_free, i_clk, i_rst_n, o_cmd.out_load, i_stat.out_free)
    `ASSERT_NEXT(a_capture_then_decode, i_clk, i_rst_n, o_cmd.capture, r_state == ST_DECODE)
    `ASSERT_IMPLIES(a_done_in_wait, i_clk, i_rst_n, i_stat.mul_done, w_in_wait)

endmodule

FILE: rtl/striped_multiply_rotate_hash64.sv
// Top level of the striped multiply-rotate 64-bit hash block.
//
//  Channel   Direction  Handshake              Payload
//  in        request    i_in_valid/o_in_stall  data_word, first/last, seed, length
//  out       result     o_out_valid/i_out_stall hash_value
//  cfg       write      i_cfg_valid/o_cfg_ready rotation set bit
//
// Each 64-bit multiply is built from 32x32 products on one multiplier; an absorbed word
// takes one multiply and a word past the length only steps the position; a first word
// also seeds the lanes and a last word also runs the fold and finalizer.
// Reset is synchronous and active low; it clears the lanes, position and length.
// The finished hash waits in an output register while the next message is taken in; the
// next last word stalls the input until that register is free.
module striped_multiply_rotate_hash64 import smrh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [WORD_W-1:0] i_data_word,
    input  logic              i_first_word,
    input  logic              i_last_word,
    input  logic [WORD_W-1:0] i_seed_value,
    input  logic [LEN_W-1:0]  i_message_bytes,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [WORD_W-1:0] o_hash_value,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    smrh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    smrh_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_data_word     (i_data_word),
        .i_first_word    (i_first_word),
        .i_last_word     (i_last_word),
        .i_seed_value    (i_seed_value),
        .i_message_bytes (i_message_bytes),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_hash_value    (o_hash_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall)
    );

endmodule

FILE: verif/smrh_hash_checker.sv
// Checker that predicts the hash of every message on the request channel and compares results.
`timescale 1ns / 100ps
module smrh_hash_checker import smrh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [WORD_W-1:0] i_data_word,
    input  logic              i_first_word,
    input  logic              i_last_word,
    input  logic [WORD_W-1:0] i_seed_value,
    input  logic [LEN_W-1:0]  i_message_bytes,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [WORD_W-1:0] i_hash_value,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic              i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);
    localparam logic [63:0] K_GOLD  = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] K_LANE2 = 64'h85EBCA77C2B2AE3D;
    localparam logic [63:0] K_LANE3 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] K_LANE4 = 64'h94D049BB133111EB;

    logic [63:0] lanes [4];
    logic [29:0] word_pos;
    logic [31:0] len_held;
    logic        rot_sel;
    logic [63:0] hashes_due [$];
    logic [63:0] due_hash;
    int          fails = 0;

    function automatic logic [5:0] lane_rotation(input logic sel, input logic [1:0] which);
        case ({sel, which})
            3'b000: return 6'd23;
            3'b001: return 6'd47;
            3'b010: return 6'd13;
            3'b011: return 6'd37;
            3'b100: return 6'd11;
            3'b101: return 6'd19;
            3'b110: return 6'd35;
            default: return 6'd47;
        endcase
    endfunction

    function automatic logic [63:0] mix_word(input logic [63:0] acc, input logic [63:0] word,
                                             input logic [5:0] k);
        logic [63:0] turned;
        turned = (k == 6'd0) ? word : ((word << k) | (word >> (7'd64 - k)));
        return (acc ^ turned) * K_GOLD;
    endfunction

    function automatic logic [63:0] finalize(input logic [63:0] folded);
        logic [63:0] h;
        h = folded;
        h = (h ^ (h >> 29)) * K_LANE2;
        h = (h ^ (h >> 31)) * K_LANE3;
        h = (h ^ (h >> 37)) * K_GOLD;
        return h ^ (h >> 41);
    endfunction

    task automatic clear_message();
        for (int i = 0; i < 4; i++) lanes[i] = '0;
        word_pos = '0;
        len_held = '0;
    endtask

    task automatic absorb_word(input logic [63:0] data, input logic first, input logic last,
                               input logic [63:0] seed, input logic [31:0] len);
        logic [63:0] base;
        logic [63:0] len64;
        logic [63:0] pos;
        logic [63:0] stripe_end;
        logic [63:0] keep;
        if (first) begin
            len_held = len;
            base     = seed ^ ({32'd0, len} * K_GOLD);
            lanes[0] = base * K_GOLD;
            lanes[1] = base * K_LANE2;
            lanes[2] = base * K_LANE3;
            lanes[3] = base * K_LANE4;
            word_pos = '0;
        end
        len64      = {32'd0, len_held};
        pos        = {31'd0, word_pos, 3'd0};
        stripe_end = ({36'd0, word_pos[29:2]} + 64'd1) << 5;
        if (stripe_end <= len64) begin
            lanes[word_pos[1:0]] = mix_word(lanes[word_pos[1:0]], data,
                                            lane_rotation(rot_sel, word_pos[1:0]));
        end else if (pos + 64'd8 <= len64) begin
            lanes[0] = mix_word(lanes[0], data, lane_rotation(rot_sel, 2'd0));
        end else if (pos < len64) begin
            keep     = (64'd1 << ((len64 - pos) * 8)) - 64'd1;
            lanes[0] = mix_word(lanes[0], data & keep, lane_rotation(rot_sel, 2'd0));
        end
        if (word_pos != '1) word_pos = word_pos + 30'd1;
        if (last) begin
            hashes_due.push_back(finalize(lanes[0] ^ lanes[1] ^ (lanes[2] ^ lanes[3])));
            clear_message();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_message();
            rot_sel = 1'b0;
            hashes_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (hashes_due.size() == 0) begin
                    $display("%0t: hash %h arrived with none expected", $time, i_hash_value);
                    fails++;
                end else begin
                    due_hash = hashes_due.pop_front();
                    if (i_hash_value !== due_hash) begin
                        $display("%0t: hash mismatch, expected %h, actual %h",
                                 $time, due_hash, i_hash_value);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_word(i_data_word, i_first_word, i_last_word, i_seed_value,
                            i_message_bytes);
            end
            if (i_cfg_valid && i_cfg_ready) rot_sel = i_cfg_data;
        end
        o_fail_count <= fails;
        o_pending    <= hashes_due.size();
    end

endmodule

FILE: verif/striped_multiply_rotate_hash64_tb.sv
// Testbench top that drives messages and rotation settings into the hash block and reports.
`timescale 1ns / 100ps
module striped_multiply_rotate_hash64_tb;
    import smrh_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [WORD_W-1:0] i_data_word;
    logic              i_first_word;
    logic              i_last_word;
    logic [WORD_W-1:0] i_seed_value;
    logic [LEN_W-1:0]  i_message_bytes;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [WORD_W-1:0] o_hash_value;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_data;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int words_sent    = 0;
    int fail_count;
    int pending;

    striped_multiply_rotate_hash64 dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_word     (i_data_word),
        .i_first_word    (i_first_word),
        .i_last_word     (i_last_word),
        .i_seed_value    (i_seed_value),
        .i_message_bytes (i_message_bytes),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hash_value    (o_hash_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    smrh_hash_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_data_word     (i_data_word),
        .i_first_word    (i_first_word),
        .i_last_word     (i_last_word),
        .i_seed_value    (i_seed_value),
        .i_message_bytes (i_message_bytes),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_hash_value    (o_hash_value),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("** striped_multiply_rotate_hash64: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic put_word(input logic [63:0] data, input logic first, input logic last,
                            input logic [63:0] seed, input logic [31:0] len);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_word     <= data;
        i_first_word    <= first;
        i_last_word     <= last;
        i_seed_value    <= seed;
        i_message_bytes <= len;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    task automatic send_message(input logic [63:0] seed, input logic [31:0] len,
                                input int nwords);
        for (int i = 0; i < nwords; i++) begin
            put_word({$urandom, $urandom}, i == 0, i == nwords - 1,
                     (i == 0) ? seed : {$urandom, $urandom}, (i == 0) ? len : $urandom);
        end
    endtask

    task automatic write_rotation(input logic sel);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= sel;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic run_messages(input int quota);
        int          stop_at;
        int          kind;
        int          pick;
        int          full;
        int          nwords;
        logic [31:0] len;
        logic [63:0] seed;
        stop_at = words_sent + quota;
        while (words_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind >= 93) begin
                repeat ($urandom_range(3, 1)) begin
                    put_word({$urandom, $urandom}, $urandom_range(3) == 0, $urandom_range(1),
                             {$urandom, $urandom}, $urandom);
                end
            end else begin
                case ($urandom_range(9))
                    0: seed = '0;
                    1: seed = '1;
                    default: seed = {$urandom, $urandom};
                endcase
                pick = $urandom_range(99);
                if (pick < 50) len = $urandom_range(40);
                else if (pick < 80) len = $urandom_range(130, 41);
                else if (pick < 95) len = $urandom_range(260, 131);
                else len = $urandom;
                if (len > 32'd260) full = 6;
                else full = (len == 0) ? 1 : int'((len + 32'd7) / 32'd8);
                if (len > 32'd260 || kind >= 85) nwords = $urandom_range(full, 1);
                else if (kind >= 75) nwords = full + $urandom_range(3, 1);
                else nwords = full;
                send_message(seed, len, nwords);
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_data_word     = '0;
        i_first_word    = 1'b0;
        i_last_word     = 1'b0;
        i_seed_value    = '0;
        i_message_bytes = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 13;
        recv_idle_pct = 62;
        write_rotation(1'b0);

        // Zero-length, single-word and partial-word messages with extreme values, then 32- and 45-byte messages.
        put_word('1, 1'b1, 1'b1, '0, 32'd0);
        put_word('0, 1'b1, 1'b1, '1, 32'd0);
        put_word('1, 1'b1, 1'b1, '1, 32'd8);
        put_word('1, 1'b1, 1'b1, 64'h0123456789ABCDEF, 32'd1);
        put_word('1, 1'b1, 1'b1, {$urandom, $urandom}, 32'd7);
        send_message({$urandom, $urandom}, 32'd32, 4);
        send_message({$urandom, $urandom}, 32'd45, 6);
        // Maximum length closed early, then words running past the length.
        send_message('1, 32'hFFFF_FFFF, 2);
        send_message({$urandom, $urandom}, 32'd9, 3);
        // Requests that arrive without a first word.
        put_word({$urandom, $urandom}, 1'b0, 1'b0, {$urandom, $urandom}, $urandom);
        put_word({$urandom, $urandom}, 1'b0, 1'b1, {$urandom, $urandom}, $urandom);

        settle();
        write_rotation(1'b1);
        run_messages(176);

        settle();
        send_idle_pct = 62;
        recv_idle_pct = 13;
        write_rotation(1'b0);
        run_messages(176);

        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_rotation(1'b1);
        run_messages(176);

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("** striped_multiply_rotate_hash64: PASSED **");
        end else begin
            $display("** striped_multiply_rotate_hash64: FAILED **");
        end
        $finish;
    end

endmodule
